### design/gfau_pkg.sv
// ----------------------------------------------------------------------------
// gfau_pkg
// Types, opcodes and the field multiply shared by the GF(2^8) arithmetic unit.
// ----------------------------------------------------------------------------
package gfau_pkg;

    // field geometry
    localparam int unsigned FIELD_BITS = 8;
    localparam int unsigned POLY_BITS  = FIELD_BITS + 1;
    localparam int unsigned EXP_BITS   = 8;

    typedef logic [FIELD_BITS-1:0] t_elem;
    typedef logic [POLY_BITS-1:0]  t_poly;
    typedef logic [EXP_BITS-1:0]   t_exp;

    // reset polynomial x^8+x^4+x^3+x^2+1
    localparam t_poly POLY_RESET = 9'h11D;

    // inverse exponent 2^n - 2
    localparam t_exp INV_EXP = 8'hFE;

    // number of square-and-multiply steps, one per exponent bit
    localparam int unsigned POW_STAGES = EXP_BITS;

    // operation codes
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_MUL = 3'd1,
        OP_DIV = 3'd2,
        OP_INV = 3'd3,
        OP_POW = 3'd4
    } t_op;

    // input transaction
    typedef struct packed {
        t_op   op;
        t_elem left;
        t_elem right;
    } t_in_item;

    // output transaction
    typedef struct packed {
        t_elem value;
        logic  error;
    } t_out_item;

    // working state carried down the power pipeline
    typedef struct packed {
        t_elem acc;     // running product
        t_elem sq;      // base squared once per step
        t_exp  expo;    // remaining exponent bits, lsb first
        t_elem factor;  // final multiplier
        logic  error;
    } t_pow_state;

    // polynomial multiply reduced by the low polynomial bits
    function automatic t_elem gf_mul(input t_elem a, input t_elem b, input t_elem low);
        t_elem acc;
        t_elem sh;
        logic  carry;
        acc = '0;
        sh  = a;
        for (int i = 0; i < FIELD_BITS; i++) begin
            if (b[i]) begin
                acc = acc ^ sh;
            end
            carry = sh[FIELD_BITS-1];
            sh    = {sh[FIELD_BITS-2:0], 1'b0};
            if (carry) begin
                sh = sh ^ low;
            end
        end
        return acc;
    endfunction

endpackage

### design/gfau_pow_stage.sv
// ----------------------------------------------------------------------------
// gfau_pow_stage
// One registered square-and-multiply step with a valid/ready slot.
// ----------------------------------------------------------------------------
module gfau_pow_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gfau_pkg::t_elem     i_poly_low,
    input  logic                i_valid,
    output logic                o_ready,
    input  gfau_pkg::t_pow_state i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output gfau_pkg::t_pow_state o_data
);

    logic                 r_valid;
    gfau_pkg::t_pow_state r_data;
    gfau_pkg::t_pow_state n_data;

    // slot can take a transaction when empty or draining
    assign o_ready = !r_valid || i_ready;

    // multiply in the current square on a set exponent bit, then square
    always_comb begin
        n_data        = i_data;
        n_data.acc    = i_data.expo[0] ?
                        gfau_pkg::gf_mul(i_data.acc, i_data.sq, i_poly_low) : i_data.acc;
        n_data.sq     = gfau_pkg::gf_mul(i_data.sq, i_data.sq, i_poly_low);
        n_data.expo   = {1'b0, i_data.expo[gfau_pkg::EXP_BITS-1:1]};
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### design/gf256_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// gf256_arithmetic_unit
// GF(2^8) add, multiply, divide, inverse and power with a writable polynomial.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries op, left and right; output channel
//   o_valid/i_ready carries value and error. One transaction per cycle is
//   accepted and one result per cycle is delivered, in order, unless the
//   output is stalled. Every operation is mapped onto base^exponent * factor:
//   eight registered square-and-multiply steps (one per exponent bit) and one
//   registered final multiply. Each step holds one multiplier pair in its path.
//   Divide and inverse of zero return value 0 with error set; unused opcodes
//   return 0.
//   The polynomial register is written through i_cfg_we/i_cfg_wdata; the user
//   must write it only while the unit is idle, as the unit does not enforce
//   this. Its top bit is always treated as set.
//   Reset (i_rst_n low, synchronous) empties every stage and loads 0x11D.
//   When i_ready is low, results stay in place; each stage keeps accepting
//   until it is full, so o_ready only drops once the pipeline has filled.
// ----------------------------------------------------------------------------
module gf256_arithmetic_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  gfau_pkg::t_poly      i_cfg_wdata,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  gfau_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output gfau_pkg::t_out_item  o_data
);

    localparam int unsigned NSTAGE = gfau_pkg::POW_STAGES;

    gfau_pkg::t_poly      r_poly;
    gfau_pkg::t_elem      poly_low;
    gfau_pkg::t_pow_state entry;

    logic                 stg_valid [0:NSTAGE];
    logic                 stg_ready [0:NSTAGE];
    gfau_pkg::t_pow_state stg_data  [0:NSTAGE];

    logic                 r_out_valid;
    gfau_pkg::t_out_item  r_out_data;
    gfau_pkg::t_out_item  n_out_data;
    logic                 out_ready;

    // polynomial register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= gfau_pkg::POLY_RESET;
        end else if (i_cfg_we) begin
            r_poly <= i_cfg_wdata;
        end
    end

    assign poly_low = r_poly[gfau_pkg::FIELD_BITS-1:0];

    // map each operation onto base, exponent and final factor
    always_comb begin
        entry.acc    = gfau_pkg::t_elem'(1);
        entry.sq     = '0;
        entry.expo   = '0;
        entry.factor = '0;
        entry.error  = 1'b0;
        case (i_data.op)
            gfau_pkg::OP_ADD: begin
                entry.factor = i_data.left ^ i_data.right;
            end
            gfau_pkg::OP_MUL: begin
                entry.sq     = i_data.left;
                entry.expo   = gfau_pkg::t_exp'(1);
                entry.factor = i_data.right;
            end
            gfau_pkg::OP_DIV: begin
                entry.sq     = i_data.right;
                entry.expo   = gfau_pkg::INV_EXP;
                entry.error  = (i_data.right == '0);
                entry.factor = entry.error ? '0 : i_data.left;
            end
            gfau_pkg::OP_INV: begin
                entry.sq     = i_data.left;
                entry.expo   = gfau_pkg::INV_EXP;
                entry.error  = (i_data.left == '0);
                entry.factor = entry.error ? '0 : gfau_pkg::t_elem'(1);
            end
            gfau_pkg::OP_POW: begin
                entry.sq     = i_data.left;
                entry.expo   = i_data.right[gfau_pkg::EXP_BITS-1:0];
                entry.factor = gfau_pkg::t_elem'(1);
            end
            default: begin
                entry.factor = '0;
            end
        endcase
    end

    assign stg_valid[0] = i_valid;
    assign stg_data[0]  = entry;
    assign o_ready      = stg_ready[0];

    // square-and-multiply chain, one exponent bit per stage
    for (genvar k = 0; k < NSTAGE; k++) begin : g_pow
        gfau_pow_stage u_stage (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_poly_low (poly_low),
            .i_valid    (stg_valid[k]),
            .o_ready    (stg_ready[k]),
            .i_data     (stg_data[k]),
            .o_valid    (stg_valid[k+1]),
            .i_ready    (stg_ready[k+1]),
            .o_data     (stg_data[k+1])
        );
    end

    // final multiply into the output register
    assign out_ready          = !r_out_valid || i_ready;
    assign stg_ready[NSTAGE]  = out_ready;

    always_comb begin
        n_out_data.error = stg_data[NSTAGE].error;
        n_out_data.value = stg_data[NSTAGE].error ? '0 :
                           gfau_pkg::gf_mul(stg_data[NSTAGE].acc,
                                            stg_data[NSTAGE].factor, poly_low);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= stg_valid[NSTAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && stg_valid[NSTAGE]) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    // reset loads the default polynomial
    a_poly_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_poly == gfau_pkg::POLY_RESET)
        else $error("polynomial not reset to default");

    // an error result always carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.error |-> r_out_data.value == '0)
        else $error("error result with nonzero value");

    // an error entering the chain has its factor cleared
    a_err_factor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stg_valid[1] && stg_data[1].error |-> stg_data[1].factor == '0)
        else $error("error transaction with nonzero factor");

    // the first stage blocks the input only when it holds a transaction and downstream is stalled
    a_stall_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> stg_valid[1] && !stg_ready[1])
        else $error("input stalled while first stage can move");

endmodule

### tb/gf256_arithmetic_unit_checker.sv
// ----------------------------------------------------------------------------
// gf256_arithmetic_unit_checker
// Watches both channels of the GF(2^8) unit, predicts every result from the
// accepted operands and the current polynomial, and compares in order.
// ----------------------------------------------------------------------------
module gf256_arithmetic_unit_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  gfau_pkg::t_poly      i_cfg_wdata,
    input  logic                 i_valid,
    input  logic                 i_in_ready,
    input  gfau_pkg::t_in_item   i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_ready,
    input  gfau_pkg::t_out_item  i_out_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    // multiplicative inverse is a^(2^8 - 2)
    localparam gfau_pkg::t_exp INVERSE_POWER = 8'd254;

    gfau_pkg::t_poly     field_poly;
    gfau_pkg::t_out_item gf_predicted[$];

    // shift-and-add product, reduced by the low polynomial taps
    function automatic gfau_pkg::t_elem field_product(input gfau_pkg::t_elem a,
                                                      input gfau_pkg::t_elem b,
                                                      input gfau_pkg::t_elem taps);
        gfau_pkg::t_elem prod;
        gfau_pkg::t_elem run;
        prod = '0;
        run  = a;
        for (int k = 0; k < gfau_pkg::FIELD_BITS; k++) begin
            if (b[k]) begin
                prod ^= run;
            end
            if (run[gfau_pkg::FIELD_BITS-1]) begin
                run = (run << 1) ^ taps;
            end else begin
                run = run << 1;
            end
        end
        return prod;
    endfunction

    // square-and-multiply over all exponent bits
    function automatic gfau_pkg::t_elem field_power(input gfau_pkg::t_elem base,
                                                    input gfau_pkg::t_exp expo,
                                                    input gfau_pkg::t_elem taps);
        gfau_pkg::t_elem acc;
        gfau_pkg::t_elem sq;
        acc = 8'd1;
        sq  = base;
        for (int k = 0; k < gfau_pkg::EXP_BITS; k++) begin
            if (expo[k]) begin
                acc = field_product(acc, sq, taps);
            end
            sq = field_product(sq, sq, taps);
        end
        return acc;
    endfunction

    // expected result of one operation
    function automatic gfau_pkg::t_out_item gf_evaluate(input gfau_pkg::t_in_item item,
                                                        input gfau_pkg::t_poly poly);
        gfau_pkg::t_out_item res;
        gfau_pkg::t_elem     taps;
        taps      = poly[gfau_pkg::FIELD_BITS-1:0];
        res.value = '0;
        res.error = 1'b0;
        case (item.op)
            gfau_pkg::OP_ADD: begin
                res.value = item.left ^ item.right;
            end
            gfau_pkg::OP_MUL: begin
                res.value = field_product(item.left, item.right, taps);
            end
            gfau_pkg::OP_DIV: begin
                if (item.right == '0) begin
                    res.error = 1'b1;
                end else begin
                    res.value = field_product(item.left,
                        field_power(item.right, INVERSE_POWER, taps), taps);
                end
            end
            gfau_pkg::OP_INV: begin
                if (item.left == '0) begin
                    res.error = 1'b1;
                end else begin
                    res.value = field_power(item.left, INVERSE_POWER, taps);
                end
            end
            gfau_pkg::OP_POW: begin
                res.value = field_power(item.left, item.right, taps);
            end
            default: begin
                res.value = '0;
            end
        endcase
        return res;
    endfunction

    // track polynomial, queue predictions, compare results
    always @(posedge i_clk) begin
        gfau_pkg::t_out_item want;
        if (!i_rst_n) begin
            field_poly = gfau_pkg::POLY_RESET;
            gf_predicted.delete();
        end else begin
            if (i_cfg_we) begin
                field_poly = i_cfg_wdata;
            end
            if (i_valid && i_in_ready) begin
                gf_predicted.push_back(gf_evaluate(i_in_data, field_poly));
            end
            if (i_out_valid && i_ready) begin
                if (gf_predicted.size() == 0) begin
                    $error("result transaction with nothing expected: value %0h error %0b",
                           i_out_data.value, i_out_data.error);
                    o_fail_count++;
                end else begin
                    want = gf_predicted.pop_front();
                    o_checked++;
                    if (i_out_data.value !== want.value) begin
                        $error("value mismatch: expected %0h actual %0h",
                               want.value, i_out_data.value);
                        o_fail_count++;
                    end
                    if (i_out_data.error !== want.error) begin
                        $error("error mismatch: expected %0b actual %0b",
                               want.error, i_out_data.error);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = gf_predicted.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

endmodule

### tb/gf256_arithmetic_unit_tb.sv
// ----------------------------------------------------------------------------
// gf256_arithmetic_unit_tb
// Drives corner-case and random operations through the GF(2^8) unit under a
// series of reduction polynomials, with random idling on both channels and
// one long output stall; the checker module does all result comparison.
// ----------------------------------------------------------------------------
module gf256_arithmetic_unit_tb;

    // opcodes the unit does not define
    localparam logic [2:0] OP_RSVD_LO  = 3'd5;
    localparam logic [2:0] OP_RSVD_MID = 3'd6;
    localparam logic [2:0] OP_RSVD_HI  = 3'd7;

    localparam int PIPE_LATENCY   = 9;
    localparam int ITEMS_PER_POLY = 210;
    localparam int STALL_CYCLES   = 120;
    localparam int NUM_POLYS      = 8;

    // polynomial sequence; one slot is replaced by a random value
    localparam gfau_pkg::t_poly POLY_LIST [NUM_POLYS] = '{
        9'h12B, 9'h100, 9'h1FF, 9'h01D, 9'h163, 9'h000, 9'h1E7, 9'h11D
    };
    localparam int RANDOM_SLOT = 5;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    gfau_pkg::t_poly     i_cfg_wdata;
    logic                i_valid;
    logic                o_ready;
    gfau_pkg::t_in_item  i_data;
    logic                o_valid;
    logic                i_ready;
    gfau_pkg::t_out_item o_data;

    int   fail_count;
    int   pending;
    int   checked;
    int   items_sent;
    int   polys_used;
    logic calm_window;

    // no idling on either side through this stretch
    assign calm_window = (items_sent >= 900) && (items_sent < 1150);

    gf256_arithmetic_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

    gf256_arithmetic_unit_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_ready      (i_ready),
        .i_out_data   (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // build one operation transaction
    function automatic gfau_pkg::t_in_item make_item(input logic [2:0] op,
                                                     input gfau_pkg::t_elem left,
                                                     input gfau_pkg::t_elem right);
        gfau_pkg::t_in_item item;
        item.op    = gfau_pkg::t_op'(op);
        item.left  = left;
        item.right = right;
        return item;
    endfunction

    // operand biased toward zero, one and all-ones
    function automatic gfau_pkg::t_elem pick_operand();
        int roll;
        roll = $urandom_range(15);
        if (roll == 0) begin
            return 8'h00;
        end else if (roll == 1) begin
            return 8'hFF;
        end else if (roll == 2) begin
            return 8'h01;
        end
        return gfau_pkg::t_elem'($urandom_range(255));
    endfunction

    // mostly defined opcodes, a few reserved ones
    function automatic logic [2:0] pick_opcode();
        if ($urandom_range(99) < 4) begin
            return 3'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
        end
        return 3'($urandom_range(gfau_pkg::OP_POW, gfau_pkg::OP_ADD));
    endfunction

    // present one transaction, with random idle cycles ahead of it
    task automatic send_op(input gfau_pkg::t_in_item item);
        while (!calm_window && ($urandom_range(99) < 18)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        items_sent++;
    endtask

    // stop offering and let every result come out
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_poly(input gfau_pkg::t_poly poly);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= poly;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        polys_used++;
    endtask

    // result side: random back-pressure plus one long hold-off
    initial begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && items_sent >= 400) begin
                held      = 1'b1;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (calm_window) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= 18);
            end
        end
    end

    // watchdog
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // stimulus and verdict
    initial begin
        gfau_pkg::t_poly poly;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = gfau_pkg::POLY_RESET;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_data      = '0;
        items_sent  = 0;
        polys_used  = 1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corner cases under the reset polynomial
        send_op(make_item(gfau_pkg::OP_ADD, 8'hFF, 8'h00));
        send_op(make_item(gfau_pkg::OP_ADD, 8'hA5, 8'h5A));
        send_op(make_item(gfau_pkg::OP_ADD, 8'hFF, 8'hFF));
        send_op(make_item(gfau_pkg::OP_MUL, 8'h00, 8'h37));
        send_op(make_item(gfau_pkg::OP_MUL, 8'h37, 8'h00));
        send_op(make_item(gfau_pkg::OP_MUL, 8'hFF, 8'hFF));
        send_op(make_item(gfau_pkg::OP_MUL, 8'h80, 8'h02));
        send_op(make_item(gfau_pkg::OP_MUL, 8'h01, 8'hFF));
        send_op(make_item(gfau_pkg::OP_DIV, 8'h45, 8'h00));
        send_op(make_item(gfau_pkg::OP_DIV, 8'h00, 8'h00));
        send_op(make_item(gfau_pkg::OP_DIV, 8'h00, 8'h17));
        send_op(make_item(gfau_pkg::OP_DIV, 8'hFF, 8'hFF));
        send_op(make_item(gfau_pkg::OP_DIV, 8'h01, 8'hFF));
        send_op(make_item(gfau_pkg::OP_INV, 8'h00, 8'hFF));
        send_op(make_item(gfau_pkg::OP_INV, 8'h01, 8'h00));
        send_op(make_item(gfau_pkg::OP_INV, 8'h02, 8'h00));
        send_op(make_item(gfau_pkg::OP_INV, 8'h02, 8'hFF));
        send_op(make_item(gfau_pkg::OP_INV, 8'hFF, 8'hAB));
        send_op(make_item(gfau_pkg::OP_POW, 8'h00, 8'h00));
        send_op(make_item(gfau_pkg::OP_POW, 8'h00, 8'h05));
        send_op(make_item(gfau_pkg::OP_POW, 8'hFF, 8'h00));
        send_op(make_item(gfau_pkg::OP_POW, 8'h02, 8'hFF));
        send_op(make_item(gfau_pkg::OP_POW, 8'h02, 8'h80));
        send_op(make_item(OP_RSVD_LO, 8'hFF, 8'hFF));
        send_op(make_item(OP_RSVD_MID, 8'h5A, 8'hA5));
        send_op(make_item(OP_RSVD_HI, 8'h00, 8'h00));
        drain();

        // random operations, one phase per polynomial
        for (int p = 0; p < NUM_POLYS; p++) begin
            poly = (p == RANDOM_SLOT) ? gfau_pkg::t_poly'($urandom_range(511))
                                      : POLY_LIST[p];
            write_poly(poly);
            for (int n = 0; n < ITEMS_PER_POLY; n++) begin
                send_op(make_item(pick_opcode(), pick_operand(), pick_operand()));
            end
            drain();
        end

        $display("ran %0d operations under %0d polynomial settings, %0d results compared",
                 items_sent, polys_used, checked);
        $display("covered zero operands, reserved opcodes, top-bit-clear polynomial, long stall");
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
